### rtl/scht_pkg.sv
`timescale 1ns / 1ps

package scht_pkg;

   localparam int TIME_W     = 16;
   localparam int CUR_W      = TIME_W + 1;
   localparam int IDX_MAX_W  = 5;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic POLICY_RM  = 1'b0;
   localparam logic POLICY_EDF = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_LIMIT = 2'd2;

   typedef logic [TIME_W-1:0] time_type;

   typedef struct packed {
      time_type arrival;
      time_type deadline;
      time_type budget;
      time_type period;
   } entry_type;

   typedef struct packed {
      logic                 load;
      logic [IDX_MAX_W-1:0] load_idx;
      entry_type            load_entry;
      logic                 run;
      logic [IDX_MAX_W-1:0] run_idx;
   } table_cmd_type;

   typedef struct packed {
      logic                 miss;
      logic [IDX_MAX_W-1:0] miss_idx;
      logic                 have;
      logic [IDX_MAX_W-1:0] run_idx;
   } pick_type;

   function automatic time_type sat_add(time_type a, time_type b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

endpackage

### rtl/scht_table.sv
`timescale 1ns / 1ps

module scht_table #(
   parameter int MAX_TASKS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scht_pkg::table_cmd_type  cmd,
   output scht_pkg::entry_type      entries [MAX_TASKS],
   output logic [MAX_TASKS-1:0]     end_hit
);
   import scht_pkg::*;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_lane
      entry_type entry_ff, entry_in;
      time_type  count_ff, count_in;
      time_type  cnt_inc, need, arr_new;
      logic      hit_load, hit_run;

      assign hit_load = cmd.load && (cmd.load_idx == IDX_MAX_W'(g));
      assign hit_run  = cmd.run && (cmd.run_idx == IDX_MAX_W'(g));

      // run count saturates; a zero budget behaves as one
      assign cnt_inc    = (count_ff == '1) ? count_ff : count_ff + TIME_W'(1);
      assign need       = (entry_ff.budget == '0) ? TIME_W'(1) : entry_ff.budget;
      assign end_hit[g] = cnt_inc >= need;
      assign arr_new    = sat_add(entry_ff.arrival, entry_ff.period);

      always_comb begin
         entry_in = entry_ff;
         count_in = count_ff;
         if (hit_load) begin
            entry_in = cmd.load_entry;
            count_in = '0;
         end else if (hit_run) begin
            if (end_hit[g]) begin
               entry_in.arrival  = arr_new;
               entry_in.deadline = sat_add(arr_new, entry_ff.period);
               count_in          = '0;
            end else begin
               count_in = cnt_inc;
            end
         end
      end

      always_ff @(posedge clock) begin
         entry_ff <= entry_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff <= '0;
         end else begin
            count_ff <= count_in;
         end
      end

      assign entries[g] = entry_ff;
   end

endmodule

### rtl/scht_select.sv
`timescale 1ns / 1ps

module scht_select #(
   parameter int MAX_TASKS = 8
) (
   input  scht_pkg::entry_type              entries [MAX_TASKS],
   input  logic [scht_pkg::CUR_W-1:0]       cur_time,
   input  logic                             policy_mode,
   input  logic [scht_pkg::CNT_W-1:0]       task_count,
   output scht_pkg::pick_type               pick
);
   import scht_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int NP    = 1 << IDX_W;

   logic [MAX_TASKS-1:0] ready;
   logic [MAX_TASKS-1:0] late;
   logic                 node_vld [2*NP];
   time_type             node_key [2*NP];
   logic [IDX_W-1:0]     node_idx [2*NP];
   logic [IDX_W-1:0]     miss_idx;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_flag
      logic active;
      assign active   = int'(task_count) > g;
      assign ready[g] = active && ({1'b0, entries[g].arrival} <= cur_time);
      assign late[g]  = active && ({1'b0, entries[g].deadline} <= cur_time);
   end

   // min tree, heap ordered; left wins ties so the lower index is kept
   always_comb begin
      for (int k = 0; k < 2 * NP; k++) begin
         node_vld[k] = 1'b0;
         node_key[k] = '0;
         node_idx[k] = '0;
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
         node_vld[NP+i] = ready[i];
         node_key[NP+i] = (policy_mode == POLICY_EDF) ? entries[i].deadline
                                                      : entries[i].period;
         node_idx[NP+i] = IDX_W'(i);
      end
      for (int k = NP - 1; k >= 1; k--) begin
         if (node_vld[2*k] && (!node_vld[2*k+1] || node_key[2*k] <= node_key[2*k+1])) begin
            node_vld[k] = 1'b1;
            node_key[k] = node_key[2*k];
            node_idx[k] = node_idx[2*k];
         end else begin
            node_vld[k] = node_vld[2*k+1];
            node_key[k] = node_key[2*k+1];
            node_idx[k] = node_idx[2*k+1];
         end
      end
   end

   always_comb begin
      miss_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (late[i]) begin
            miss_idx = IDX_W'(i);
         end
      end
   end

   assign pick.miss     = |late;
   assign pick.miss_idx = IDX_MAX_W'(miss_idx);
   assign pick.have     = node_vld[1];
   assign pick.run_idx  = IDX_MAX_W'(node_idx[1]);

endmodule

### rtl/periodic_task_tick_scheduler_core.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_type, task index, arrival, budget,
//         |           |                       | first deadline, period
// rsp     | out       | rsp_valid / rsp_ready | time, run, start/end, miss, halt, limit
// csr     | in        | csr_we (no wait)      | csr_index, csr_wdata
//
// One item per cycle unless rsp stalls; a req goes via the request and result registers.
// The request register feeds the selection tree and table update, the result
// register holds the answer. Table and time state update as the result is registered.
// Reset is synchronous and clears control state and run counts; table entries
// hold garbage until loaded. A stalled rsp freezes the result register; the request
// register still takes one transfer, then req_ready stays low until rsp_ready returns.

module periodic_task_tick_scheduler_core #(
   parameter int MAX_TASKS = 8
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [2:0]                          req_task_index,
   input  logic [15:0]                         req_arrival_time,
   input  logic [15:0]                         req_exec_budget,
   input  logic [15:0]                         req_first_deadline,
   input  logic [15:0]                         req_task_period,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_time_now,
   output logic                                rsp_run_valid,
   output logic [2:0]                          rsp_run_task,
   output logic                                rsp_started,
   output logic                                rsp_ended,
   output logic                                rsp_missed,
   output logic [2:0]                          rsp_missed_task,
   output logic                                rsp_halted,
   output logic                                rsp_past_limit,

   input  logic                                csr_we,
   input  logic [scht_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scht_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import scht_pkg::*;

   // configuration
   logic             policy_ff, policy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   time_type         limit_ff, limit_in;

   // request stage
   logic             in_vld_ff, in_vld_in;
   logic             type_ff;
   logic [2:0]       index_ff;
   entry_type        entry_ff;

   // scheduler state
   logic [CUR_W-1:0]     time_ff, time_in;
   logic                 halt_ff, halt_in;
   logic                 last_vld_ff, last_vld_in;
   logic [IDX_MAX_W-1:0] last_idx_ff, last_idx_in;

   // result stage
   logic       out_vld_ff, out_vld_in;
   time_type   time_now_ff;
   logic       run_ff, started_ff, ended_ff, missed_ff, halted_ff, past_ff;
   logic [2:0] run_task_ff, miss_task_ff;

   logic          out_free, step, req_fire;
   logic          is_tick, over, act, miss_now, run_now, past_now, started_now;
   time_type      shown_time;
   entry_type     entries [MAX_TASKS];
   logic [MAX_TASKS-1:0] end_hit;
   pick_type      pick;
   table_cmd_type cmd;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign step      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      limit_in  = limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:     policy_in = csr_wdata[0];
            CSR_TASK_COUNT: count_in  = csr_wdata[CNT_W-1:0];
            CSR_TIME_LIMIT: limit_in  = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   scht_select #(.MAX_TASKS(MAX_TASKS)) u_select (
      .entries     (entries),
      .cur_time    (time_ff),
      .policy_mode (policy_ff),
      .task_count  (count_ff),
      .pick        (pick)
   );

   assign is_tick     = type_ff == REQ_TICK;
   assign over        = time_ff > {1'b0, limit_ff};
   assign act         = step && is_tick && !halt_ff && !over;
   assign miss_now    = act && pick.miss;
   assign run_now     = act && !pick.miss && pick.have;
   assign past_now    = is_tick && !halt_ff && over;
   assign started_now = run_now && (!last_vld_ff || last_idx_ff != pick.run_idx);
   assign shown_time  = time_ff[TIME_W] ? '1 : time_ff[TIME_W-1:0];

   always_comb begin
      cmd.load       = step && !is_tick && (int'(index_ff) < MAX_TASKS);
      cmd.load_idx   = IDX_MAX_W'(index_ff);
      cmd.load_entry = entry_ff;
      cmd.run        = run_now;
      cmd.run_idx    = pick.run_idx;
   end

   scht_table #(.MAX_TASKS(MAX_TASKS)) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .entries (entries),
      .end_hit (end_hit)
   );

   always_comb begin
      time_in     = time_ff;
      halt_in     = halt_ff | miss_now;
      last_vld_in = last_vld_ff;
      last_idx_in = last_idx_ff;
      if (act && !pick.miss) begin
         time_in = time_ff + CUR_W'(1);
      end
      if (run_now) begin
         last_vld_in = 1'b1;
         last_idx_in = pick.run_idx;
      end
   end

   assign in_vld_in  = req_fire || (in_vld_ff && !step);
   assign out_vld_in = step || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_RM;
         count_ff    <= CNT_W'(1);
         limit_ff    <= '1;
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         time_ff     <= '0;
         halt_ff     <= 1'b0;
         last_vld_ff <= 1'b0;
         last_idx_ff <= '0;
      end else begin
         policy_ff   <= policy_in;
         count_ff    <= count_in;
         limit_ff    <= limit_in;
         in_vld_ff   <= in_vld_in;
         out_vld_ff  <= out_vld_in;
         time_ff     <= time_in;
         halt_ff     <= halt_in;
         last_vld_ff <= last_vld_in;
         last_idx_ff <= last_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff           <= req_type;
         index_ff          <= req_task_index;
         entry_ff.arrival  <= req_arrival_time;
         entry_ff.budget   <= req_exec_budget;
         entry_ff.deadline <= req_first_deadline;
         entry_ff.period   <= req_task_period;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         time_now_ff  <= shown_time;
         run_ff       <= run_now;
         run_task_ff  <= run_now ? pick.run_idx[2:0] : 3'd0;
         started_ff   <= started_now;
         ended_ff     <= run_now && end_hit[pick.run_idx[$clog2(MAX_TASKS)-1:0]];
         missed_ff    <= miss_now;
         miss_task_ff <= miss_now ? pick.miss_idx[2:0] : 3'd0;
         halted_ff    <= halt_in;
         past_ff      <= past_now;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_time_now    = time_now_ff;
   assign rsp_run_valid   = run_ff;
   assign rsp_run_task    = run_task_ff;
   assign rsp_started     = started_ff;
   assign rsp_ended       = ended_ff;
   assign rsp_missed      = missed_ff;
   assign rsp_missed_task = miss_task_ff;
   assign rsp_halted      = halted_ff;
   assign rsp_past_limit  = past_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag dropped without reset");

   a_miss_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_missed |-> rsp_halted && !rsp_run_valid)
      else $error("deadline miss without halt, or with a task run");

   a_end_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ended || rsp_started) |-> rsp_run_valid)
      else $error("start or end flagged with no task run");

   a_time_hold_on_miss: assert property (@(posedge clock) disable iff (reset)
      miss_now |=> $stable(time_ff))
      else $error("time advanced on a deadline miss");

endmodule
